// ===== rtl/m3i_pkg.sv =====
// Package for the 3x3 matrix inverse: element width, payload item types and an
// element lookup helper. Depends on nothing; used by the top level and the tb.
package m3i_pkg;

    localparam int ELEM_W = 32;

    typedef struct packed {
        logic signed [ELEM_W-1:0] m_r0_c0;
        logic signed [ELEM_W-1:0] m_r1_c0;
        logic signed [ELEM_W-1:0] m_r2_c0;
        logic signed [ELEM_W-1:0] m_r0_c1;
        logic signed [ELEM_W-1:0] m_r1_c1;
        logic signed [ELEM_W-1:0] m_r2_c1;
        logic signed [ELEM_W-1:0] m_r0_c2;
        logic signed [ELEM_W-1:0] m_r1_c2;
        logic signed [ELEM_W-1:0] m_r2_c2;
    } t_mat_in;

    typedef struct packed {
        logic signed [ELEM_W-1:0] inv_r0_c0;
        logic signed [ELEM_W-1:0] inv_r1_c0;
        logic signed [ELEM_W-1:0] inv_r2_c0;
        logic signed [ELEM_W-1:0] inv_r0_c1;
        logic signed [ELEM_W-1:0] inv_r1_c1;
        logic signed [ELEM_W-1:0] inv_r2_c1;
        logic signed [ELEM_W-1:0] inv_r0_c2;
        logic signed [ELEM_W-1:0] inv_r1_c2;
        logic signed [ELEM_W-1:0] inv_r2_c2;
        logic                     singular;
        logic                     overflow;
    } t_mat_out;

    // Element at row r, column c of an input matrix.
    function automatic logic signed [ELEM_W-1:0] elem(t_mat_in m, int r, int c);
        logic signed [ELEM_W-1:0] v;
        unique case (r * 3 + c)
            0:       v = m.m_r0_c0;
            1:       v = m.m_r0_c1;
            2:       v = m.m_r0_c2;
            3:       v = m.m_r1_c0;
            4:       v = m.m_r1_c1;
            5:       v = m.m_r1_c2;
            6:       v = m.m_r2_c0;
            7:       v = m.m_r2_c1;
            default: v = m.m_r2_c2;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/m3i_div_stage.sv =====
// One registered step of the nine-lane restoring divider of the matrix inverse.
// Depends on nothing but its parameters; instantiated once per quotient bit.
module m3i_div_stage #(
    parameter int XW     = 131,
    parameter int QW     = 32,
    parameter int BIT    = 31,
    parameter int SIDE_W = 307
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_valid,
    input  logic [XW-1:0]          i_den,
    input  logic [8:0][XW-1:0]     i_rem,
    input  logic [8:0][QW-1:0]     i_q,
    input  logic [SIDE_W-1:0]      i_side,
    output logic                   o_valid,
    output logic [XW-1:0]          o_den,
    output logic [8:0][XW-1:0]     o_rem,
    output logic [8:0][QW-1:0]     o_q,
    output logic [SIDE_W-1:0]      o_side
);

    logic                 r_valid;
    logic [XW-1:0]        r_den;
    logic [8:0][XW-1:0]   r_rem, n_rem;
    logic [8:0][QW-1:0]   r_q, n_q;
    logic [SIDE_W-1:0]    r_side;
    logic [XW-1:0]        w_sub;

    // Subtract the shifted divisor wherever it fits and record the quotient bit.
    always_comb begin
        w_sub = i_den << BIT;
        for (int l = 0; l < 9; l++) begin
            n_rem[l] = i_rem[l];
            n_q[l]   = i_q[l];
            if (i_rem[l] >= w_sub) begin
                n_rem[l]     = i_rem[l] - w_sub;
                n_q[l][BIT]  = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_den  <= i_den;
            r_rem  <= n_rem;
            r_q    <= n_q;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_den   = r_den;
    assign o_rem   = r_rem;
    assign o_q     = r_q;
    assign o_side  = r_side;

endmodule

// ===== rtl/matrix3x3_inverse.sv =====
// Top level of the fixed-point 3x3 matrix inverse (adjugate over determinant).
// Depends on m3i_pkg and m3i_div_stage.
//
// Usage: one 3x3 matrix of signed fixed-point elements enters per item on the
// input channel (i_in_valid, o_in_stall, i_in_data); one result item leaves on
// the output channel (o_out_valid, i_out_stall, o_out_data). Each result holds
// the nine inverse elements, a singular flag and an overflow flag.
// An item is taken at a clock edge where valid is high and stall is low.
//
// The pipeline is 8 + ELEM_W register stages deep: an input register, two
// stages for the 2x2 minors and cofactors (32x32 multiplies, then their
// differences), two for the determinant (split partial products, then their
// sum), one for magnitudes, one for the overflow pre-check, one stage per
// quotient bit of the restoring divider that all nine elements run in lanes,
// and the output register. While the output is not stalled, a new matrix may
// enter in every cycle, so the sustained rate is one item per cycle; the
// divider's one-bit-per-stage chain sets the latency.
//
// A zero determinant returns the input matrix unchanged with singular set.
// Quotients outside the element range saturate and set overflow.
// Reset clears every valid bit. When the receiver stalls with a result waiting,
// the whole pipeline holds and o_in_stall rises; nothing is lost or repeated.
module matrix3x3_inverse #(
    parameter int FRAC_BITS = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  m3i_pkg::t_mat_in i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output m3i_pkg::t_mat_out o_out_data
);

    localparam int W      = m3i_pkg::ELEM_W;
    localparam int PW     = 2 * W;          // minor product
    localparam int CW     = 2 * W + 1;      // cofactor, signed
    localparam int LW     = W + 1;          // low slice of a cofactor, unsigned
    localparam int DW     = 3 * W + 3;      // determinant, signed
    localparam int NW     = CW + 2 * FRAC_BITS;
    localparam int XW     = (NW > DW + W) ? NW : DW + W;
    localparam int MW     = $bits(m3i_pkg::t_mat_in);
    localparam int SIDE_W = MW + 19;

    // The whole pipeline advances together unless a finished result is held.
    logic w_en;
    assign w_en       = !o_out_valid || !i_out_stall;
    assign o_in_stall = !w_en;

    // Stage 1: input register.
    logic             r1_v;
    m3i_pkg::t_mat_in r1_m;

    // Stage 2: the eighteen products of the 2x2 minors.
    logic                   r2_v;
    m3i_pkg::t_mat_in       r2_m;
    logic signed [PW-1:0]   r2_pa [3][3];
    logic signed [PW-1:0]   r2_pb [3][3];

    // Stage 3: signed cofactors.
    logic                   r3_v;
    m3i_pkg::t_mat_in       r3_m;
    logic signed [CW-1:0]   r3_cof [3][3];
    logic signed [CW-1:0]   n3_cof [3][3];

    // Stage 4: determinant partial products along row 0.
    logic                   r4_v;
    m3i_pkg::t_mat_in       r4_m;
    logic signed [CW-1:0]   r4_cof [3][3];
    logic signed [2*W+1:0]  r4_dl [3];
    logic signed [2*W-1:0]  r4_dh [3];

    // Stage 5: determinant.
    logic                   r5_v;
    m3i_pkg::t_mat_in       r5_m;
    logic signed [CW-1:0]   r5_cof [3][3];
    logic signed [DW-1:0]   r5_det;
    logic signed [DW-1:0]   n5_det;

    // Stage 6: magnitudes, result signs and the singular test.
    logic                   r6_v;
    m3i_pkg::t_mat_in       r6_m;
    logic [8:0][XW-1:0]     r6_num, n6_num;
    logic [XW-1:0]          r6_den, n6_den;
    logic [8:0]             r6_neg, n6_neg;
    logic                   r6_zero;

    // Stage 7: a quotient of 2^W or more saturates whatever its sign.
    logic                   r7_v;
    m3i_pkg::t_mat_in       r7_m;
    logic [8:0][XW-1:0]     r7_num;
    logic [XW-1:0]          r7_den;
    logic [8:0]             r7_neg, r7_sat, n7_sat;
    logic                   r7_zero;

    always_comb begin
        logic signed [CW-1:0] t;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                t = CW'(r2_pa[r][c]) - CW'(r2_pb[r][c]);
                n3_cof[r][c] = ((r + c) % 2 == 1) ? -t : t;
            end
        end
    end

    always_comb begin
        logic signed [DW-1:0] hi;
        logic signed [DW-1:0] lo;
        n5_det = '0;
        for (int c = 0; c < 3; c++) begin
            hi     = DW'(r4_dh[c]);
            lo     = DW'(r4_dl[c]);
            n5_det = n5_det + (hi <<< LW) + lo;
        end
    end

    always_comb begin
        logic signed [CW-1:0] cv;
        logic [CW-1:0]        ca;
        logic [DW-1:0]        da;
        da     = r5_det[DW-1] ? DW'(-r5_det) : DW'(r5_det);
        n6_den = {{(XW-DW){1'b0}}, da};
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                // Inverse element (r, c) comes from the transposed cofactor (c, r).
                cv = r5_cof[c][r];
                ca = cv[CW-1] ? CW'(-cv) : CW'(cv);
                n6_num[r*3+c] = {{(XW-CW){1'b0}}, ca} << (2 * FRAC_BITS);
                n6_neg[r*3+c] = cv[CW-1] ^ r5_det[DW-1];
            end
        end
    end

    always_comb begin
        for (int k = 0; k < 9; k++) begin
            n7_sat[k] = r6_num[k] >= (r6_den << W);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
            r6_v <= 1'b0;
            r7_v <= 1'b0;
        end else if (w_en) begin
            r1_v <= i_in_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
            r5_v <= r4_v;
            r6_v <= r5_v;
            r7_v <= r6_v;
        end
        if (w_en) begin
            r1_m <= i_in_data;
            r2_m <= r1_m;
            r3_m <= r2_m;
            r4_m <= r3_m;
            r5_m <= r4_m;
            r6_m <= r5_m;
            r7_m <= r6_m;
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r2_pa[r][c] <=
                        PW'(m3i_pkg::elem(r1_m, (r == 0) ? 1 : 0, (c == 0) ? 1 : 0))
                      * PW'(m3i_pkg::elem(r1_m, (r == 2) ? 1 : 2, (c == 2) ? 1 : 2));
                    r2_pb[r][c] <=
                        PW'(m3i_pkg::elem(r1_m, (r == 0) ? 1 : 0, (c == 2) ? 1 : 2))
                      * PW'(m3i_pkg::elem(r1_m, (r == 2) ? 1 : 2, (c == 0) ? 1 : 0));
                end
            end
            r3_cof <= n3_cof;
            r4_cof <= r3_cof;
            for (int c = 0; c < 3; c++) begin
                r4_dl[c] <= (2*W+2)'(m3i_pkg::elem(r3_m, 0, c))
                          * (2*W+2)'($signed({1'b0, r3_cof[0][c][W:0]}));
                r4_dh[c] <= PW'(m3i_pkg::elem(r3_m, 0, c))
                          * PW'($signed(r3_cof[0][c][2*W:W+1]));
            end
            r5_cof  <= r4_cof;
            r5_det  <= n5_det;
            r6_num  <= n6_num;
            r6_den  <= n6_den;
            r6_neg  <= n6_neg;
            r6_zero <= (r5_det == '0);
            r7_num  <= r6_num;
            r7_den  <= r6_den;
            r7_neg  <= r6_neg;
            r7_sat  <= n7_sat;
            r7_zero <= r6_zero;
        end
    end

    // Divider chain: stage s resolves quotient bit W-1-s for all nine lanes.
    logic                 w_v    [W+1];
    logic [XW-1:0]        w_den  [W+1];
    logic [8:0][XW-1:0]   w_rem  [W+1];
    logic [8:0][W-1:0]    w_q    [W+1];
    logic [SIDE_W-1:0]    w_side [W+1];

    assign w_v[0]    = r7_v;
    assign w_den[0]  = r7_den;
    assign w_rem[0]  = r7_num;
    assign w_q[0]    = '0;
    assign w_side[0] = {r7_m, r7_neg, r7_sat, r7_zero};

    for (genvar s = 0; s < W; s++) begin : g_div
        m3i_div_stage #(
            .XW     (XW),
            .QW     (W),
            .BIT    (W - 1 - s),
            .SIDE_W (SIDE_W)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_v[s]),
            .i_den   (w_den[s]),
            .i_rem   (w_rem[s]),
            .i_q     (w_q[s]),
            .i_side  (w_side[s]),
            .o_valid (w_v[s+1]),
            .o_den   (w_den[s+1]),
            .o_rem   (w_rem[s+1]),
            .o_q     (w_q[s+1]),
            .o_side  (w_side[s+1])
        );
    end

    // Final stage: sign, saturation and the singular bypass.
    m3i_pkg::t_mat_in  w_fm;
    logic [8:0]        w_fneg, w_fsat;
    logic              w_fzero;
    logic [8:0][W-1:0] w_res;
    logic              w_ovf;
    logic              r_out_v;
    m3i_pkg::t_mat_out r_out, n_out;

    assign {w_fm, w_fneg, w_fsat, w_fzero} = w_side[W];

    always_comb begin
        logic [W-1:0] q;
        logic         big;
        w_ovf = 1'b0;
        for (int k = 0; k < 9; k++) begin
            q = w_q[W][k];
            if (w_fneg[k]) begin
                big = w_fsat[k] || (q[W-1] && (q[W-2:0] != '0));
                w_res[k] = big ? {1'b1, {(W-1){1'b0}}} : W'(-q);
            end else begin
                big = w_fsat[k] || q[W-1];
                w_res[k] = big ? {1'b0, {(W-1){1'b1}}} : q;
            end
            w_ovf = w_ovf | big;
        end
        if (w_fzero) begin
            n_out.inv_r0_c0 = w_fm.m_r0_c0;
            n_out.inv_r1_c0 = w_fm.m_r1_c0;
            n_out.inv_r2_c0 = w_fm.m_r2_c0;
            n_out.inv_r0_c1 = w_fm.m_r0_c1;
            n_out.inv_r1_c1 = w_fm.m_r1_c1;
            n_out.inv_r2_c1 = w_fm.m_r2_c1;
            n_out.inv_r0_c2 = w_fm.m_r0_c2;
            n_out.inv_r1_c2 = w_fm.m_r1_c2;
            n_out.inv_r2_c2 = w_fm.m_r2_c2;
            n_out.singular  = 1'b1;
            n_out.overflow  = 1'b0;
        end else begin
            n_out.inv_r0_c0 = w_res[0];
            n_out.inv_r0_c1 = w_res[1];
            n_out.inv_r0_c2 = w_res[2];
            n_out.inv_r1_c0 = w_res[3];
            n_out.inv_r1_c1 = w_res[4];
            n_out.inv_r1_c2 = w_res[5];
            n_out.inv_r2_c0 = w_res[6];
            n_out.inv_r2_c1 = w_res[7];
            n_out.inv_r2_c2 = w_res[8];
            n_out.singular  = 1'b0;
            n_out.overflow  = w_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_en) begin
            r_out_v <= w_v[W];
        end
        if (w_en) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out;

endmodule

// ===== sim/tb.sv =====
// Testbench for the fixed-point 3x3 matrix inverse: directed and random matrices,
// checked against an exact adjugate-over-determinant predictor. Depends on m3i_pkg.
`timescale 1ns / 1ps

module tb;

    typedef m3i_pkg::t_mat_in  t_mat_in;
    typedef m3i_pkg::t_mat_out t_mat_out;

    localparam int ELEM_W = m3i_pkg::ELEM_W;
    localparam int FRAC = 16;
    localparam int LATENCY = 8 + ELEM_W;
    localparam longint CYCLE_LIMIT = 400000;

    logic     i_clk;
    logic     i_rst_n;
    logic     i_in_valid;
    logic     o_in_stall;
    t_mat_in  i_in_data;
    logic     o_out_valid;
    logic     i_out_stall;
    t_mat_out o_out_data;

    // Inverses still owed by the block, oldest first.
    t_mat_out pending_inverses[$];
    int       mismatches;
    longint   cycle_count;
    logic     stall_enable;
    int       out_wait;

    matrix3x3_inverse #(.FRAC_BITS(FRAC)) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Exact inverse. Elements are widened to 256 bits so that neither the
    // determinant nor the scaled cofactors can wrap; division truncates
    // towards zero, and the quotient saturates at the element range.
    function automatic t_mat_out invert_matrix(t_mat_in m);
        logic signed [255:0] a[3][3];
        logic signed [255:0] cof[3][3];
        logic signed [255:0] det, num, quo, hi_lim, lo_lim;
        logic signed [ELEM_W-1:0] inv[3][3];
        t_mat_out res;
        int r1, r2, c1, c2;
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
                a[r][c] = 256'(signed'(m3i_pkg::elem(m, r, c)));
        for (int r = 0; r < 3; r++) begin
            r1 = (r == 0) ? 1 : 0;
            r2 = (r == 2) ? 1 : 2;
            for (int c = 0; c < 3; c++) begin
                c1 = (c == 0) ? 1 : 0;
                c2 = (c == 2) ? 1 : 2;
                cof[r][c] = a[r1][c1] * a[r2][c2] - a[r1][c2] * a[r2][c1];
                if ((r + c) % 2 == 1) cof[r][c] = -cof[r][c];
            end
        end
        det = a[0][0] * cof[0][0] + a[0][1] * cof[0][1] + a[0][2] * cof[0][2];
        if (det == 0) begin
            res = '{m.m_r0_c0, m.m_r1_c0, m.m_r2_c0, m.m_r0_c1, m.m_r1_c1,
                    m.m_r2_c1, m.m_r0_c2, m.m_r1_c2, m.m_r2_c2, 1'b1, 1'b0};
            return res;
        end
        hi_lim = (256'sd1 <<< (ELEM_W - 1)) - 1;
        lo_lim = -(256'sd1 <<< (ELEM_W - 1));
        res = '0;
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++) begin
                // The adjugate is the transposed cofactor matrix.
                num = cof[c][r] <<< (2 * FRAC);
                quo = num / det;
                if (quo > hi_lim) begin
                    quo = hi_lim;
                    res.overflow = 1'b1;
                end else if (quo < lo_lim) begin
                    quo = lo_lim;
                    res.overflow = 1'b1;
                end
                inv[r][c] = quo[ELEM_W-1:0];
            end
        res.inv_r0_c0 = inv[0][0]; res.inv_r1_c0 = inv[1][0]; res.inv_r2_c0 = inv[2][0];
        res.inv_r0_c1 = inv[0][1]; res.inv_r1_c1 = inv[1][1]; res.inv_r2_c1 = inv[2][1];
        res.inv_r0_c2 = inv[0][2]; res.inv_r1_c2 = inv[1][2]; res.inv_r2_c2 = inv[2][2];
        return res;
    endfunction

    // Hands one matrix over after an optional random gap, holding it while stalled.
    // Valid stays high after acceptance so that a back-to-back item needs no
    // second assignment in the same time step.
    task automatic send_matrix(t_mat_in m, bit allow_gap);
        int gap;
        gap = allow_gap ? $urandom_range(0, 19) : 0;
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= m;
        do @(posedge i_clk); while (o_in_stall);
        pending_inverses = {pending_inverses, invert_matrix(m)};
    endtask

    function automatic t_mat_in matrix_from(logic signed [ELEM_W-1:0] e[9]);
        return '{e[0], e[1], e[2], e[3], e[4], e[5], e[6], e[7], e[8]};
    endfunction

    function automatic logic signed [ELEM_W-1:0] random_element(int style);
        case (style)
            0: return $urandom;
            1: return $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
            2: return $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
            default: return $signed($urandom_range(0, 16)) - 8;
        endcase
    endfunction

    // Extremes, identity, scaled diagonals, singular and saturating matrices.
    task automatic test_directed();
        logic signed [ELEM_W-1:0] e[9];
        e = '{default: 0};
        send_matrix(matrix_from(e), 1);
        e = '{32'h10000, 0, 0, 0, 32'h10000, 0, 0, 0, 32'h10000};
        send_matrix(matrix_from(e), 1);
        e = '{32'h20000, 0, 0, 0, -32'sh40000, 0, 0, 0, 32'h8000};
        send_matrix(matrix_from(e), 1);
        e = '{1, 0, 0, 0, 1, 0, 0, 0, 1};
        send_matrix(matrix_from(e), 1);
        e = '{default: 32'sh7fff_ffff};
        send_matrix(matrix_from(e), 1);
        e = '{default: 32'sh8000_0000};
        send_matrix(matrix_from(e), 1);
        e = '{default: 32'shffff_ffff};
        send_matrix(matrix_from(e), 1);
        e = '{32'sh8000_0000, 0, 0, 0, 32'sh8000_0000, 0, 0, 0, 32'sh8000_0000};
        send_matrix(matrix_from(e), 1);
        e = '{32'sh7fff_ffff, 0, 0, 0, 32'sh7fff_ffff, 0, 0, 0, 32'sh7fff_ffff};
        send_matrix(matrix_from(e), 1);
        e = '{-1, 0, 0, 0, -1, 0, 0, 0, -1};
        send_matrix(matrix_from(e), 1);
        // Two equal rows make the determinant zero with nonzero elements.
        e = '{32'h10000, 32'h10000, 32'h5, 32'h20000, 32'h20000, 32'h7,
              32'h30000, 32'h30000, -32'sh9};
        send_matrix(matrix_from(e), 1);
        e = '{32'sh8000_0000, 32'sh7fff_ffff, 1, 32'sh7fff_ffff, 32'sh8000_0000,
              -1, 1, -1, 32'sh8000_0000};
        send_matrix(matrix_from(e), 1);
        e = '{0, 32'h10000, 0, 0, 0, 32'h10000, 32'h10000, 0, 0};
        send_matrix(matrix_from(e), 1);
        e = '{32'sh5555_5555, 32'shaaaa_aaaa, 32'sh1234_5678, 32'shedcb_a987,
              32'sh0f0f_0f0f, 32'shf0f0_f0f0, 32'sh3333_3333, 32'shcccc_cccc, 7};
        send_matrix(matrix_from(e), 1);
    endtask

    // Random matrices of mixed magnitude, a fifth of them made singular.
    task automatic test_random(int count);
        logic signed [ELEM_W-1:0] e[9];
        int style;
        for (int n = 0; n < count; n++) begin
            style = $urandom_range(0, 3);
            foreach (e[k]) e[k] = random_element($urandom_range(0, 4) == 0 ? 0 : style);
            if ($urandom_range(0, 4) == 0) begin
                // Copy one column onto another (a rank-deficient matrix).
                e[6] = e[0]; e[7] = e[1]; e[8] = e[2];
            end
            send_matrix(matrix_from(e), n % 100 >= 30);
        end
    endtask

    // Receiver: after each result taken it may stall for a randomly drawn wait
    // before the next, with a stall-free stretch when disabled.
    always @(posedge i_clk) begin
        int draw;
        if (!i_rst_n || !stall_enable) begin
            i_out_stall <= 1'b0;
            out_wait    <= 0;
        end else if (o_out_valid && !i_out_stall) begin
            draw = $urandom_range(0, 19);
            out_wait    <= draw;
            i_out_stall <= (draw != 0);
        end else if (out_wait > 1) begin
            out_wait    <= out_wait - 1;
            i_out_stall <= 1'b1;
        end else begin
            out_wait    <= 0;
            i_out_stall <= 1'b0;
        end
    end

    // Compares each accepted result with the oldest expected inverse.
    always @(posedge i_clk) begin
        t_mat_out want;
        cycle_count <= cycle_count + 1;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_inverses.size() == 0) begin
                $display("%0t: unexpected result %h", $time, o_out_data);
                mismatches++;
            end else begin
                want = pending_inverses.pop_front();
                if (o_out_data !== want) begin
                    $display("%0t: expected %h actual %h", $time, want, o_out_data);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycle_count > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        mismatches   = 0;
        cycle_count  = 0;
        stall_enable = 1'b0;
        out_wait     = 0;
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_in_data    = '0;
        i_out_stall  = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        stall_enable <= 1'b1;
        test_random(270);
        stall_enable <= 1'b0;
        test_random(60);
        stall_enable <= 1'b1;
        test_random(220);
        i_in_valid <= 1'b0;
        while (pending_inverses.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (mismatches == 0 && pending_inverses.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule

// ===== sim.f =====
rtl/m3i_pkg.sv
rtl/m3i_div_stage.sv
rtl/matrix3x3_inverse.sv
sim/tb.sv
